FILE: rtl/core/anem_pkg.sv
// Package for the anemometer pulse period and phase block.
// Holds widths, reset values, status codes and register decode constants.
// No dependencies.
`timescale 1ns / 1ps

package anem_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int IN_TIME_WIDTH  = 32;
    localparam int PERIOD_WIDTH   = 32;
    localparam int ANGLE_WIDTH    = 9;
    localparam int DEB_WIDTH      = 20;
    localparam int ADDR_WIDTH     = 3;
    localparam int DATA_WIDTH     = 32;

    localparam logic [DEB_WIDTH-1:0] DEB_RESET = 20'd20000;

    // Word select on paddr[2]; the only register sits at word 0.
    localparam logic REG_DEBOUNCE = 1'b0;

    typedef enum logic [1:0] {
        OP_SPEED   = 2'd0,
        OP_DIR     = 2'd1,
        OP_MEASURE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SPEED = 3'd1,
        ST_BAD_DIR   = 3'd2,
        ST_BAD_ORDER = 3'd3,
        ST_NO_ANGLE  = 3'd4
    } status_t;

endpackage

FILE: rtl/core/anemometer_pulse_period_and_phase.sv
// Top level of the anemometer pulse period and phase block.
// Depends on anem_pkg for widths, status codes and the debounce reset value.
// Holds the sequencer, timestamp state and one shared add/subtract unit.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid/in_stall, fields op and time_us): op 0 is a speed
//   reed pulse, op 1 a direction reed pulse, op 2 a measure request; op 3 is
//   ignored. A transfer happens when in_valid is high and in_stall is low.
// - Output channel (out_valid/out_stall): one transfer per measure request
//   carrying status, period_us and angle_deg. Pulses produce no output.
// - All work runs through a single add/subtract/compare unit stepped by a
//   small sequencer, so in_stall is high while an item is in progress.
//   A pulse takes a distance step and a debounce compare. A measure runs
//   speed, direction and order checks, period, lag and a lag compare, a
//   multiply by 360 in 3 shift-add steps, 9 restoring divide steps and an
//   emit step that loads the output register. A failing check ends it early.
// - The output register parts the two sides: a new item is taken while a
//   result is still waiting. When the receiver stalls and a second result is
//   ready, the sequencer holds in its emit step until the slot frees.
// - Reset clears all timestamps to zero, loads the 20000 us debounce and
//   drops any pending output. The debounce register is written over APB.
module anemometer_pulse_period_and_phase
    import anem_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               op,
    input  logic [IN_TIME_WIDTH-1:0] time_us,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               status,
    output logic [PERIOD_WIDTH-1:0]  period_us,
    output logic [ANGLE_WIDTH-1:0]   angle_deg,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_WIDTH-1:0]    paddr,
    input  logic [DATA_WIDTH-1:0]    pwdata,
    output logic [DATA_WIDTH-1:0]    prdata,
    output logic                     pready
);

    // Unit width: lag * 360 needs TIME_WIDTH + 9 bits.
    localparam int UW = TIME_WIDTH + ANGLE_WIDTH;
    localparam int CW = $clog2(ANGLE_WIDTH);
    localparam logic [CW-1:0] DIV_LAST = CW'(ANGLE_WIDTH - 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_PULSE_DIFF,
        S_PULSE_CMP,
        S_SPD_DIFF,
        S_SPD_DEB,
        S_DIR_DIFF,
        S_DIR_DEB,
        S_ORD_HEAD,
        S_ORD_TAIL,
        S_PERIOD,
        S_LAG,
        S_LAG_CMP,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_DIV,
        S_EMIT
    } state_t;

    // control and architectural state (reset)
    state_t                  state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [PERIOD_WIDTH-1:0] out_period_reg, out_period_next;
    logic [ANGLE_WIDTH-1:0]  out_angle_reg, out_angle_next;
    logic [DEB_WIDTH-1:0]    deb_reg, deb_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [TIME_WIDTH-1:0]   spd_time_reg, spd_time_next;
    logic [TIME_WIDTH-1:0]   spd_prev_reg, spd_prev_next;
    logic [TIME_WIDTH-1:0]   snap_time_reg, snap_time_next;
    logic [TIME_WIDTH-1:0]   snap_prev_reg, snap_prev_next;
    logic [TIME_WIDTH-1:0]   dir_time_reg, dir_time_next;
    logic [TIME_WIDTH-1:0]   dir_prev_reg, dir_prev_next;
    logic [TIME_WIDTH-1:0]   spd_acc_reg, spd_acc_next;
    logic [TIME_WIDTH-1:0]   dir_acc_reg, dir_acc_next;

    // working registers (no reset)
    logic                    is_dir_reg, is_dir_next;
    status_t                 st_reg, st_next;
    logic [TIME_WIDTH-1:0]   now_reg, now_next;
    logic [TIME_WIDTH-1:0]   diff_reg, diff_next;
    logic [TIME_WIDTH-1:0]   ds_reg, ds_next;
    logic [TIME_WIDTH-1:0]   dd_reg, dd_next;
    logic [TIME_WIDTH-1:0]   lag_head_reg, lag_head_next;
    logic [TIME_WIDTH-1:0]   lag_tail_reg, lag_tail_next;
    logic [TIME_WIDTH-1:0]   period_reg, period_next;
    logic [TIME_WIDTH-1:0]   lag_reg, lag_next;
    logic [UW-1:0]           acc_reg, acc_next;
    logic [TIME_WIDTH-1:0]   rem_reg, rem_next;
    logic [ANGLE_WIDTH-1:0]  low_reg, low_next;
    logic [ANGLE_WIDTH-1:0]  quo_reg, quo_next;

    // shared unit
    logic [UW-1:0] ua, ub;
    logic          usub;
    logic [UW:0]   ufull;
    logic [UW-1:0] ures;
    logic          ucarry;
    logic          ures_zero;

    logic in_xfer, out_free, cfg_write, any_zero;

    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign period_us = out_period_reg;
    assign angle_deg = out_angle_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_DEBOUNCE) ? DATA_WIDTH'(deb_reg) : '0;

    // One adder: a + b, or a - b with carry high meaning a >= b.
    assign ufull     = {1'b0, ua} + {1'b0, (usub ? ~ub : ub)} + (UW+1)'(usub);
    assign ures      = ufull[UW-1:0];
    assign ucarry    = ufull[UW];
    assign ures_zero = (ures == '0);

    assign any_zero = (dir_time_reg == '0) || (dir_prev_reg == '0) ||
                      (snap_time_reg == '0) || (snap_prev_reg == '0);

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_period_next = out_period_reg;
        out_angle_next  = out_angle_reg;
        deb_next        = deb_reg;
        cnt_next        = cnt_reg;
        spd_time_next   = spd_time_reg;
        spd_prev_next   = spd_prev_reg;
        snap_time_next  = snap_time_reg;
        snap_prev_next  = snap_prev_reg;
        dir_time_next   = dir_time_reg;
        dir_prev_next   = dir_prev_reg;
        spd_acc_next    = spd_acc_reg;
        dir_acc_next    = dir_acc_reg;
        is_dir_next     = is_dir_reg;
        st_next         = st_reg;
        now_next        = now_reg;
        diff_next       = diff_reg;
        ds_next         = ds_reg;
        dd_next         = dd_reg;
        lag_head_next   = lag_head_reg;
        lag_tail_next   = lag_tail_reg;
        period_next     = period_reg;
        lag_next        = lag_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        low_next        = low_reg;
        quo_next        = quo_reg;
        ua              = '0;
        ub              = '0;
        usub            = 1'b1;

        if (cfg_write && paddr[2] == REG_DEBOUNCE)
        begin
            deb_next = pwdata[DEB_WIDTH-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    now_next    = TIME_WIDTH'(time_us);
                    is_dir_next = (op == OP_DIR);
                    unique case (op_t'(op))
                        OP_SPEED, OP_DIR: state_next = S_PULSE_DIFF;
                        OP_MEASURE:       state_next = S_SPD_DIFF;
                        OP_NONE:          state_next = S_IDLE;
                    endcase
                end
            end
            S_PULSE_DIFF:
            begin
                // wrapping distance from the last accepted pulse
                ua         = UW'(now_reg);
                ub         = UW'(is_dir_reg ? dir_acc_reg : spd_acc_reg);
                diff_next  = ures[TIME_WIDTH-1:0];
                state_next = S_PULSE_CMP;
            end
            S_PULSE_CMP:
            begin
                // accept when debounce < distance
                ua = UW'(deb_reg);
                ub = UW'(diff_reg);
                if (!ucarry)
                begin
                    if (is_dir_reg)
                    begin
                        dir_prev_next  = dir_time_reg;
                        dir_time_next  = now_reg;
                        snap_prev_next = spd_prev_reg;
                        snap_time_next = spd_time_reg;
                        dir_acc_next   = now_reg;
                    end
                    else
                    begin
                        spd_prev_next = spd_time_reg;
                        spd_time_next = now_reg;
                        spd_acc_next  = now_reg;
                    end
                end
                state_next = S_IDLE;
            end
            S_SPD_DIFF:
            begin
                ua      = UW'(snap_time_reg);
                ub      = UW'(snap_prev_reg);
                ds_next = ures[TIME_WIDTH-1:0];
                if (!ucarry || ures_zero)
                begin
                    st_next    = ST_BAD_SPEED;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SPD_DEB;
                end
            end
            S_SPD_DEB:
            begin
                ua = UW'(ds_reg);
                ub = UW'(deb_reg);
                if (!ucarry)
                begin
                    st_next    = ST_BAD_SPEED;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DIR_DIFF;
                end
            end
            S_DIR_DIFF:
            begin
                ua      = UW'(dir_time_reg);
                ub      = UW'(dir_prev_reg);
                dd_next = ures[TIME_WIDTH-1:0];
                if (!ucarry || ures_zero)
                begin
                    st_next    = ST_BAD_DIR;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DIR_DEB;
                end
            end
            S_DIR_DEB:
            begin
                ua = UW'(dd_reg);
                ub = UW'(deb_reg);
                if (!ucarry)
                begin
                    st_next    = ST_BAD_DIR;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_ORD_HEAD;
                end
            end
            S_ORD_HEAD:
            begin
                // direction pulse must trail the earlier speed pulse
                ua            = UW'(dir_prev_reg);
                ub            = UW'(snap_prev_reg);
                lag_head_next = ures[TIME_WIDTH-1:0];
                if (any_zero || !ucarry || ures_zero)
                begin
                    st_next    = ST_BAD_ORDER;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_ORD_TAIL;
                end
            end
            S_ORD_TAIL:
            begin
                ua            = UW'(dir_time_reg);
                ub            = UW'(snap_time_reg);
                lag_tail_next = ures[TIME_WIDTH-1:0];
                if (!ucarry)
                begin
                    st_next    = ST_BAD_ORDER;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_PERIOD;
                end
            end
            S_PERIOD:
            begin
                // mean of the two intervals from the full-width sum
                usub        = 1'b0;
                ua          = UW'(ds_reg);
                ub          = UW'(dd_reg);
                period_next = ures[TIME_WIDTH:1];
                state_next  = S_LAG;
            end
            S_LAG:
            begin
                usub       = 1'b0;
                ua         = UW'(lag_head_reg);
                ub         = UW'(lag_tail_reg);
                lag_next   = ures[TIME_WIDTH:1];
                state_next = S_LAG_CMP;
            end
            S_LAG_CMP:
            begin
                ua = UW'(lag_reg);
                ub = UW'(period_reg);
                if (lag_reg == '0 || ucarry)
                begin
                    st_next    = ST_NO_ANGLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_MUL_A;
                end
            end
            // lag * 360 = lag * (256 + 64 + 32 + 8)
            S_MUL_A:
            begin
                usub       = 1'b0;
                ua         = UW'(lag_reg) << 8;
                ub         = UW'(lag_reg) << 6;
                acc_next   = ures;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                usub       = 1'b0;
                ua         = acc_reg;
                ub         = UW'(lag_reg) << 5;
                acc_next   = ures;
                state_next = S_MUL_C;
            end
            S_MUL_C:
            begin
                // quotient fits 9 bits, so start with the top of the product
                usub       = 1'b0;
                ua         = acc_reg;
                ub         = UW'(lag_reg) << 3;
                rem_next   = ures[UW-1:ANGLE_WIDTH];
                low_next   = ures[ANGLE_WIDTH-1:0];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // restoring divide, one quotient bit per step
                ua       = UW'({rem_reg, low_reg[ANGLE_WIDTH-1]});
                ub       = UW'(period_reg);
                low_next = low_reg << 1;
                quo_next = {quo_reg[ANGLE_WIDTH-2:0], ucarry};
                if (ucarry)
                begin
                    rem_next = ures[TIME_WIDTH-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[TIME_WIDTH-2:0], low_reg[ANGLE_WIDTH-1]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    st_next    = ST_OK;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold until the output slot is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_period_next = (st_reg == ST_OK || st_reg == ST_NO_ANGLE) ?
                                      PERIOD_WIDTH'(period_reg) : '0;
                    out_angle_next  = (st_reg == ST_OK) ? quo_reg : '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_period_reg <= '0;
            out_angle_reg  <= '0;
            deb_reg        <= DEB_RESET;
            cnt_reg        <= '0;
            spd_time_reg   <= '0;
            spd_prev_reg   <= '0;
            snap_time_reg  <= '0;
            snap_prev_reg  <= '0;
            dir_time_reg   <= '0;
            dir_prev_reg   <= '0;
            spd_acc_reg    <= '0;
            dir_acc_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_period_reg <= out_period_next;
            out_angle_reg  <= out_angle_next;
            deb_reg        <= deb_next;
            cnt_reg        <= cnt_next;
            spd_time_reg   <= spd_time_next;
            spd_prev_reg   <= spd_prev_next;
            snap_time_reg  <= snap_time_next;
            snap_prev_reg  <= snap_prev_next;
            dir_time_reg   <= dir_time_next;
            dir_prev_reg   <= dir_prev_next;
            spd_acc_reg    <= spd_acc_next;
            dir_acc_reg    <= dir_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_dir_reg   <= is_dir_next;
        st_reg       <= st_next;
        now_reg      <= now_next;
        diff_reg     <= diff_next;
        ds_reg       <= ds_next;
        dd_reg       <= dd_next;
        lag_head_reg <= lag_head_next;
        lag_tail_reg <= lag_tail_next;
        period_reg   <= period_next;
        lag_reg      <= lag_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        quo_reg      <= quo_next;
    end

endmodule
